@@ rtl/core/hetach_pkg.sv @@
`default_nettype none

package hetach_pkg;

  // Field and register widths
  localparam int unsigned HallW   = 3;
  localparam int unsigned TickW   = 26;
  localparam int unsigned PprW    = 8;
  localparam int unsigned EdgeW   = 28;
  localparam int unsigned SpeedW  = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 26;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_TICKS   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PULSES_PER_REV = 1'd1;

  // Register reset values
  localparam logic [TickW-1:0] WINDOW_RESET = 26'd5000000;
  localparam logic [PprW-1:0]  PPR_RESET    = 8'd24;

  // 6000000000 (centi-rpm per edge per microsecond) split as HI * 2^16 + LO
  localparam int unsigned MulHiW = 17;
  localparam int unsigned MulLoW = 16;
  localparam logic [MulHiW-1:0] SCALE_HI = 17'd91552;
  localparam logic [MulLoW-1:0] SCALE_LO = 16'd48128;

  // Divider sizes: numerator = pulses * scale, denominator = ppr * window
  localparam int unsigned ProdHiW = EdgeW + MulHiW;   // 45
  localparam int unsigned ProdLoW = EdgeW + MulLoW;   // 44
  localparam int unsigned NumW    = ProdHiW + MulLoW; // 61
  localparam int unsigned DenW    = PprW + TickW;     // 34
  localparam int unsigned CntW    = $clog2(NumW);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take one tick item
    logic mul;       // form partial products and divisor
    logic load_div;  // sum numerator, clear divider
    logic div_step;  // one restoring step
    logic finish;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic close_next; // next accepted tick closes the window
    logic out_busy;   // result register still holds an item
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/hetach_ctrl.sv @@
`default_nettype none

module hetach_ctrl
  import hetach_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              accept;

  // Stall during a division, and hold off a closing tick while the previous result is still waiting
  assign in_stall_o = (state_q != ST_RUN) || (status_i.out_busy && status_i.close_next);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_RUN: begin
        if (accept && status_i.close_next) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: begin
        state_d = ST_DIV;
        cnt_d   = CntW'(NumW - 1);
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_FIN;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_FIN: state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
  end

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.load_div = (state_q == ST_SUM);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hetach_dp.sv @@
`default_nettype none

module hetach_dp
  import hetach_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic [HallW-1:0]   hall_levels_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [EdgeW-1:0]        window_pulses_o,
  output logic [SpeedW-1:0]       speed_centi_rpm_o
);

  logic [TickW-1:0]   win_q;
  logic [PprW-1:0]    ppr_q;
  logic [HallW-1:0]   prev_q;
  logic               primed_q;
  logic [EdgeW-1:0]   edge_q;
  logic [TickW-1:0]   tick_q;
  logic               out_valid_q;

  logic [EdgeW-1:0]   pulses_q;
  logic [ProdHiW-1:0] prod_hi_q;
  logic [ProdLoW-1:0] prod_lo_q;
  logic [DenW-1:0]    den_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    rem_q;
  logic [NumW-1:0]    quot_q;
  logic [EdgeW-1:0]   wpulses_q;
  logic [SpeedW-1:0]  speed_q;

  logic [TickW-1:0]   win_eff;
  logic [PprW-1:0]    ppr_eff;
  logic [TickW-1:0]   tick_next;
  logic [HallW-1:0]   diff;
  logic [1:0]         edges;
  logic [EdgeW:0]     edge_sum;
  logic [EdgeW-1:0]   edge_sat;
  logic [DenW:0]      rem_sh;
  logic               fits;

  // Zero lengths count as one
  assign win_eff = (win_q == '0) ? TickW'(1) : win_q;
  assign ppr_eff = (ppr_q == '0) ? PprW'(1) : ppr_q;

  // Edge and tick bookkeeping for the current tick
  assign diff      = hall_levels_i ^ prev_q;
  assign edges     = primed_q ? ({1'b0, diff[0]} + {1'b0, diff[1]} + {1'b0, diff[2]}) : 2'd0;
  assign edge_sum  = {1'b0, edge_q} + {{(EdgeW - 1){1'b0}}, edges};
  assign edge_sat  = edge_sum[EdgeW] ? {EdgeW{1'b1}} : edge_sum[EdgeW-1:0];
  assign tick_next = tick_q + 1'b1;

  assign status_o.close_next = (tick_next >= win_eff) || (tick_next == '0);
  assign status_o.out_busy   = out_valid_q;

  // Restoring divider step
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  // Control state: config, counters, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WINDOW_RESET;
      ppr_q       <= PPR_RESET;
      prev_q      <= '0;
      primed_q    <= 1'b0;
      edge_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_TICKS:   win_q <= cfg_data_i;
          CFG_PULSES_PER_REV: ppr_q <= cfg_data_i[PprW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        prev_q   <= hall_levels_i;
        primed_q <= 1'b1;
        if (status_o.close_next) begin
          edge_q <= '0;
          tick_q <= '0;
        end else begin
          edge_q <= edge_sat;
          tick_q <= tick_next;
        end
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.close_next) pulses_q <= edge_sat;
    if (cmd_i.mul) begin
      prod_hi_q <= ProdHiW'(pulses_q) * ProdHiW'(SCALE_HI);
      prod_lo_q <= ProdLoW'(pulses_q) * ProdLoW'(SCALE_LO);
      den_q     <= DenW'(ppr_eff) * DenW'(win_eff);
    end
    if (cmd_i.load_div) begin
      num_q  <= {prod_hi_q, {MulLoW{1'b0}}} + NumW'(prod_lo_q);
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      quot_q <= {quot_q[NumW-2:0], fits};
      rem_q  <= fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
    end
    if (cmd_i.finish) begin
      wpulses_q <= pulses_q;
      speed_q   <= (|quot_q[NumW-1:SpeedW]) ? {SpeedW{1'b1}} : quot_q[SpeedW-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign window_pulses_o   = wpulses_q;
  assign speed_centi_rpm_o = speed_q;

endmodule

`default_nettype wire

@@ rtl/core/hall_edge_tachometer.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  hall_levels_i (3)
// out       output     out_valid_o / out_stall_i window_pulses_o (28), speed_centi_rpm_o (32)
// cfg       input      cfg_we_i                cfg_idx_i (1), cfg_data_i (26)
//
// A tick item that does not close the window is taken whenever no division is in progress.
// A closing item occupies the block while it forms the products, sums the numerator,
// then runs 61 restoring divider steps (one quotient bit per cycle) and loads the result.
// The result waits in an output register; ticks keep flowing unless the next one
// would close the window while that register is still full.
// Reset is asynchronous, active low, and restores the register defaults.
`default_nettype none

module hall_edge_tachometer
  import hetach_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [HallW-1:0]   hall_levels_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [EdgeW-1:0]        window_pulses_o,
  output logic [SpeedW-1:0]       speed_centi_rpm_o
);

  cmd_t    cmd;
  status_t status;

  hetach_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hetach_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .hall_levels_i     (hall_levels_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .window_pulses_o   (window_pulses_o),
    .speed_centi_rpm_o (speed_centi_rpm_o)
  );

`ifndef SYNTHESIS
  // Only one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.mul, cmd.load_div, cmd.div_step, cmd.finish}))
    else $error("overlapping datapath commands");

  // No tick is taken while the divider works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul || cmd.load_div || cmd.div_step || cmd.finish) |-> in_stall_o)
    else $error("input taken during division");

  // A result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_valid_o)
    else $error("result register overwritten");

  // A new result appears only after the divider finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result without division");
`endif

endmodule

`default_nettype wire

@@ test/hall_edge_tachometer_tb.sv @@
module hall_edge_tachometer_tb;
  import hetach_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 80;   // one divide plus margin
  localparam int unsigned PhaseTicks   = 47;
  localparam int unsigned RandPhases   = 16;
  localparam int unsigned ReportMax    = 10;
  localparam logic [63:0] CentiRpmUs   = 64'd6000000000;
  localparam logic [63:0] SpeedMax     = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [EdgeW-1:0]  pulses;
    logic [SpeedW-1:0] speed;
  } window_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [HallW-1:0]   hall_levels_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [EdgeW-1:0]   window_pulses_o;
  logic [SpeedW-1:0]  speed_centi_rpm_o;

  hall_edge_tachometer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .hall_levels_i,
    .out_valid_o,
    .out_stall_i,
    .window_pulses_o,
    .speed_centi_rpm_o
  );

  always #5 clk_i = ~clk_i;

  // Ticks waiting to be driven and window results waiting to come out
  logic [HallW-1:0] tick_queue[$];
  window_result_t   window_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        tick_taken = 1'b0;

  // Shadow registers and counters of the tachometer
  logic [TickW-1:0] win_reg = WINDOW_RESET;
  logic [PprW-1:0]  ppr_reg = PPR_RESET;
  logic [HallW-1:0] prev_hall = '0;
  logic             primed = 1'b0;
  logic [EdgeW-1:0] edge_acc = '0;
  logic [TickW-1:0] tick_acc = '0;

  // Speed in centi-rpm: exact 64-bit divide, truncated, saturated
  function automatic logic [SpeedW-1:0] centi_rpm(logic [EdgeW-1:0] pulses,
                                                  logic [PprW-1:0] ppr,
                                                  logic [TickW-1:0] win);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    num  = {36'b0, pulses} * CentiRpmUs;
    den  = {56'b0, (ppr == '0) ? 8'd1 : ppr} * {38'b0, win};
    quot = num / den;
    return (quot > SpeedMax) ? SpeedMax[SpeedW-1:0] : quot[SpeedW-1:0];
  endfunction

  // Count edges of one tick; close the window when the tick count reaches it
  task automatic predict_tick(logic [HallW-1:0] lv);
    logic [TickW-1:0] win;
    logic [EdgeW:0]   sum;
    window_result_t   res;
    win = (win_reg == '0) ? TickW'(1) : win_reg;
    if (primed) begin
      sum = {1'b0, edge_acc} + (EdgeW + 1)'($countones(lv ^ prev_hall));
      edge_acc = sum[EdgeW] ? '1 : sum[EdgeW-1:0];
    end else begin
      primed = 1'b1;
    end
    prev_hall = lv;
    tick_acc = tick_acc + 1'b1;
    if (tick_acc >= win || tick_acc == '0) begin
      res.pulses = edge_acc;
      res.speed  = centi_rpm(edge_acc, ppr_reg, win);
      window_results_q.push_back(res);
      edge_acc = '0;
      tick_acc = '0;
    end
  endtask

  task automatic note_mismatch(string what, window_result_t want, window_result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("%s: expected pulses %0d speed %0d, got pulses %0d speed %0d",
               what, want.pulses, want.speed, got.pulses, got.speed);
    end
  endtask

  // Tick driver: next item or an idle cycle once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || tick_taken) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          hall_levels_i <= tick_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on accepted ticks, check accepted results
  always @(posedge clk_i) begin : monitor
    window_result_t got;
    window_result_t want;
    if (rst_ni) begin
      tick_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_tick(hall_levels_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.pulses = window_pulses_o;
        got.speed  = speed_centi_rpm_o;
        if (window_results_q.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = window_results_q.pop_front();
          if (got.pulses !== want.pulses || got.speed !== want.speed) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Register write on the config port, mirrored into the shadow copy
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_WINDOW_TICKS) begin
      win_reg = data[TickW-1:0];
    end else begin
      ppr_reg = data[PprW-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every tick is taken and every result is out, then let it settle
  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (tick_queue.size() != 0 || in_valid_i || window_results_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Six-step commutation pattern of the three hall pins
  function automatic logic [HallW-1:0] hall_pattern(int pos);
    case (pos)
      0: return 3'b001;
      1: return 3'b011;
      2: return 3'b010;
      3: return 3'b110;
      4: return 3'b100;
      default: return 3'b101;
    endcase
  endfunction

  // Mostly clean rotation, with holds, reversals, skipped steps and noise
  task automatic queue_rotation(int unsigned n);
    int pos;
    int dir;
    int unsigned pick;
    pos = $urandom_range(5);
    dir = $urandom_range(1) ? 1 : 5;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        tick_queue.push_back(HallW'($urandom_range(7)));
      end else begin
        if (pick < 20) begin
          dir = 6 - dir;
        end else if (pick < 27) begin
          pos = (pos + 2 * dir) % 6;
        end else if (pick >= 35) begin
          pos = (pos + dir) % 6;
        end
        tick_queue.push_back(hall_pattern(pos));
      end
    end
  endtask

  function automatic logic [TickW-1:0] pick_window();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return TickW'($urandom_range(3));
    if (pick < 60) return TickW'($urandom_range(40, 4));
    if (pick < 70) return TickW'(64);
    if (pick < 80) return TickW'($urandom_range(63, 41));
    return TickW'($urandom_range(150, 65));
  endfunction

  function automatic logic [PprW-1:0] pick_ppr();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return '0;
    if (pick < 14) return PprW'(1);
    if (pick < 20) return '1;
    return PprW'($urandom_range(254, 2));
  endfunction

  // Junk above the 8 ppr bits must be dropped by the block
  function automatic logic [CfgW-1:0] ppr_word(logic [PprW-1:0] ppr);
    logic [CfgW-1:0] word;
    word = CfgW'($urandom);
    word[PprW-1:0] = ppr;
    return word;
  endfunction

  initial begin : stimulus
    int unsigned mode;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero window acts as one: every tick closes, priming tick gives zero
    write_reg(CFG_WINDOW_TICKS, '0);
    tick_queue = '{3'd7, 3'd0, 3'd7, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd5, 3'd2};
    settle();

    // Zero ppr acts as one; any edge in a one-tick window saturates the speed
    write_reg(CFG_PULSES_PER_REV, ppr_word('0));
    write_reg(CFG_WINDOW_TICKS, CfgW'(1));
    tick_queue = '{3'd2, 3'd2, 3'd5, 3'd4};
    settle();

    // Longest window, then shortened below the ticks already counted
    write_reg(CFG_PULSES_PER_REV, ppr_word('1));
    write_reg(CFG_WINDOW_TICKS, '1);
    queue_rotation(8);
    settle();
    write_reg(CFG_WINDOW_TICKS, CfgW'(3));
    tick_queue = '{3'd1, 3'd3};
    settle();

    // Random phases, cycling through the idle and stall patterns
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 20 : 0;
      stall_pct     = (mode == 2) ? 65 : (mode == 3) ? 20 : 0;
      write_reg(CFG_WINDOW_TICKS, CfgW'(pick_window()));
      write_reg(CFG_PULSES_PER_REV, ppr_word(pick_ppr()));
      queue_rotation(PhaseTicks);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ hall_edge_tachometer.f @@
rtl/core/hetach_pkg.sv
rtl/core/hetach_ctrl.sv
rtl/core/hetach_dp.sv
rtl/core/hall_edge_tachometer.sv
test/hall_edge_tachometer_tb.sv
